// ===== hw/rtl/pll_tuning_word_calc_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PLL_TUNING_WORD_CALC_MACROS_SVH
`define PLL_TUNING_WORD_CALC_MACROS_SVH

// Same-cycle implication.
`define PLLTW_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication with the delay given by the dly argument.
`define PLLTW_ASSERT_DELAYED(name, clk, rst, ante, dly, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/plltw_pkg.sv =====
package plltw_pkg;

   localparam int N_DIV_BITS = 12;

   localparam int FREQ_W     = 22;
   localparam int BW_W       = 27;
   localparam int REF_W      = 26;
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = REF_W - 2;
   localparam int CMP_W      = (DIVIDEND_W > DIVISOR_W + N_DIV_BITS) ?
                               DIVIDEND_W : DIVISOR_W + N_DIV_BITS;
   localparam int MUL_W      = 27;
   localparam int PROD_W     = REF_W + MUL_W;
   localparam int BASE_W     = 10;
   localparam int MHZ_W      = 7;
   localparam int LATENCY    = N_DIV_BITS + 3;

   localparam logic FUNC_TUNE = 1'b0;
   localparam logic FUNC_BW   = 1'b1;

   localparam logic [REF_W-1:0]  REF_RESET   = 26'd16000000;
   localparam logic [FREQ_W-1:0] BAND_A_MAX  = 22'd1023000;
   localparam logic [FREQ_W-1:0] BAND_B_MAX  = 22'd1300000;
   localparam logic [FREQ_W-1:0] BAND_C_MAX  = 22'd2046000;
   localparam logic [9:0]        FREQ_SCALE  = 10'd1000;
   localparam logic [BW_W-2:0]   HALF_BW_MAX = 26'd36000000;
   localparam logic [BW_W-2:0]   HALF_BW_MIN = 26'd5000000;

   // x / 100000 == (x * MUL_100K) >> SHIFT_100K, exact for 26-bit x
   localparam logic [MUL_W-1:0] MUL_100K   = 27'd87960931;
   localparam int               SHIFT_100K = 43;
   // x / 1000000 == (x * MUL_1M) >> SHIFT_1M, exact for 26-bit x
   localparam logic [MUL_W-1:0] MUL_1M     = 27'd70368745;
   localparam int               SHIFT_1M   = 46;

   localparam logic [BASE_W-1:0] TARGET_DIV4   = 10'd40;
   localparam logic [BASE_W-1:0] TARGET_DIRECT = 10'd20;
   localparam logic [4:0]        K_OFFSET      = 5'd16;
   localparam logic [4:0]        FC_OFFSET     = 5'd5;
   localparam logic [4:0]        FC_MAX        = 5'd31;

   typedef struct packed {
      logic              func;
      logic [FREQ_W-1:0] freq_khz;
      logic [BW_W-1:0]   bandwidth_hz;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic                  div4_select;
      logic                  presc32_on;
      logic [1:0]            ref_div_code;
      logic [N_DIV_BITS-1:0] n_divider;
      logic                  n_overflow;
      logic [4:0]            k_code;
      logic [4:0]            filter_code;
   } rsp_type;

   typedef struct packed {
      logic       kind;
      logic       p;
      logic       presc;
      logic [1:0] rsel;
      logic       ovf;
      logic [4:0] kc;
      logic [4:0] fc;
   } meta_type;

endpackage

// ===== hw/rtl/pll_tuning_word_calc.sv =====
// PLL tuning word calculator.
// Request channel: start with req_data; a request is taken at a clock edge with
// start high and busy low. func 0 asks for tune settings from freq_khz, func 1
// for the low-pass code from bandwidth_hz.
// Result channel: rsp_valid strobes for one cycle with rsp_data; the receiver
// must take it then, there is no back pressure.
// CSR: csr_we writes csr_wdata into the reference clock register. Write it only
// while no request is in flight.
// Pipeline: band and reciprocal multiplies, reference divider choice, divisor and
// overflow check, then one quotient bit per stage.
// Throughput: one request per cycle; busy is low whenever reset is low.
// Reset: synchronous, drops every request in flight and restores the
// reference clock register to 16 MHz.
module pll_tuning_word_calc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  plltw_pkg::req_type                req_data,
   output logic                              rsp_valid,
   output plltw_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [plltw_pkg::REF_W-1:0]       csr_wdata
);

   localparam int ND = plltw_pkg::N_DIV_BITS;

   logic                               accept;
   logic [plltw_pkg::REF_W-1:0]        refclk_ff, refclk_in;

   // stage 1
   logic                               s1_valid_ff, s1_valid_in;
   plltw_pkg::req_type                 s1_req_ff, s1_req_in;
   logic                               s1_p_ff, s1_p_in;
   logic                               s1_presc_ff, s1_presc_in;
   logic [plltw_pkg::PROD_W-1:0]       s1_base_ff, s1_base_in;
   logic [plltw_pkg::PROD_W-1:0]       s1_mhz_ff, s1_mhz_in;
   logic [plltw_pkg::DIVIDEND_W-1:0]   s1_dvd_ff, s1_dvd_in;
   logic [plltw_pkg::REF_W-1:0]        mhz_operand;

   // stage 2
   logic                               s2_valid_ff, s2_valid_in;
   plltw_pkg::meta_type                s2_meta_ff, s2_meta_in;
   logic [plltw_pkg::DIVIDEND_W-1:0]   s2_dvd_ff, s2_dvd_in;

   // divider stages
   logic [ND-1:0]                      dv_valid_ff, dv_valid_in;
   plltw_pkg::meta_type                dv_meta_ff [ND];
   plltw_pkg::meta_type                dv_meta_in [ND];
   logic [plltw_pkg::DIVIDEND_W-1:0]   dv_rem_ff  [ND];
   logic [plltw_pkg::DIVIDEND_W-1:0]   dv_rem_in  [ND];
   logic [plltw_pkg::DIVISOR_W-1:0]    dv_div_ff  [ND];
   logic [plltw_pkg::DIVISOR_W-1:0]    dv_div_in  [ND];
   logic [ND-1:0]                      dv_quo_ff  [ND];
   logic [ND-1:0]                      dv_quo_in  [ND];

   logic                               rsp_valid_ff, rsp_valid_in;
   plltw_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   assign busy   = reset;
   assign accept = start & ~busy;

   assign refclk_in = csr_we ? csr_wdata : refclk_ff;

   // stage 1: band select and multiplies
   always_comb begin
      s1_valid_in = accept;
      s1_req_in   = req_data;
      s1_p_in     = 1'b0;
      s1_presc_in = 1'b0;
      if (req_data.func == plltw_pkg::FUNC_TUNE) begin
         if (req_data.freq_khz <= plltw_pkg::BAND_A_MAX) begin
            s1_p_in = 1'b1;
         end else if (req_data.freq_khz <= plltw_pkg::BAND_B_MAX) begin
            s1_p_in     = 1'b1;
            s1_presc_in = 1'b1;
         end else if (req_data.freq_khz > plltw_pkg::BAND_C_MAX) begin
            s1_presc_in = 1'b1;
         end
      end
      mhz_operand = (req_data.func == plltw_pkg::FUNC_BW) ?
                    req_data.bandwidth_hz[plltw_pkg::BW_W-1:1] : refclk_ff;
      s1_base_in  = plltw_pkg::PROD_W'(refclk_ff) * plltw_pkg::PROD_W'(plltw_pkg::MUL_100K);
      s1_mhz_in   = plltw_pkg::PROD_W'(mhz_operand) * plltw_pkg::PROD_W'(plltw_pkg::MUL_1M);
      s1_dvd_in   = plltw_pkg::DIVIDEND_W'(req_data.freq_khz)
                    * plltw_pkg::DIVIDEND_W'(plltw_pkg::FREQ_SCALE);
   end

   // stage 2: reference divider choice, K and filter codes
   always_comb begin
      logic [plltw_pkg::BASE_W-1:0] base;
      logic [plltw_pkg::BASE_W-1:0] target;
      logic [plltw_pkg::BASE_W-1:0] cand;
      logic [plltw_pkg::BASE_W-1:0] dst;
      logic [plltw_pkg::BASE_W-1:0] best;
      logic [1:0]                   rsel;
      logic [plltw_pkg::MHZ_W-1:0]  mhz;
      logic [plltw_pkg::BW_W-2:0]   half_bw;
      logic [4:0]                   fc;

      base    = s1_base_ff[plltw_pkg::SHIFT_100K +: plltw_pkg::BASE_W];
      mhz     = s1_mhz_ff[plltw_pkg::SHIFT_1M +: plltw_pkg::MHZ_W];
      target  = s1_p_ff ? plltw_pkg::TARGET_DIV4 : plltw_pkg::TARGET_DIRECT;
      best    = '0;
      rsel    = 2'd0;
      for (int r = 0; r < 4; r++) begin
         cand = base >> (r + 1);
         dst  = (cand > target) ? (cand - target) : (target - cand);
         if (r == 0 || dst < best) begin
            best = dst;
            rsel = 2'(r);
         end
      end
      half_bw = s1_req_ff.bandwidth_hz[plltw_pkg::BW_W-1:1];
      if (half_bw > plltw_pkg::HALF_BW_MAX) begin
         fc = plltw_pkg::FC_MAX;
      end else if (half_bw < plltw_pkg::HALF_BW_MIN) begin
         fc = '0;
      end else begin
         fc = mhz[4:0] - plltw_pkg::FC_OFFSET;
      end

      s2_valid_in      = s1_valid_ff;
      s2_dvd_in        = s1_dvd_ff;
      s2_meta_in.kind  = s1_req_ff.func;
      s2_meta_in.p     = s1_p_ff;
      s2_meta_in.presc = s1_presc_ff;
      s2_meta_in.ovf   = 1'b0;
      if (s1_req_ff.func == plltw_pkg::FUNC_TUNE) begin
         s2_meta_in.rsel = rsel;
         s2_meta_in.kc   = mhz[4:0] - plltw_pkg::K_OFFSET;
         s2_meta_in.fc   = '0;
      end else begin
         s2_meta_in.rsel = 2'd0;
         s2_meta_in.kc   = '0;
         s2_meta_in.fc   = fc;
      end
   end

   // stage 3: divisor and saturation check; then one quotient bit per stage
   always_comb begin
      logic [2:0]                       shift;
      logic [plltw_pkg::REF_W-1:0]      shifted_ref;
      logic [plltw_pkg::CMP_W-1:0]      limit;
      logic [plltw_pkg::CMP_W-1:0]      sub;
      logic [plltw_pkg::DIVIDEND_W-1:0] rem;
      logic [ND-1:0]                    quo;
      plltw_pkg::meta_type              meta;

      shift          = 3'(s2_meta_ff.rsel) + 3'(s2_meta_ff.p) + 3'd2;
      shifted_ref    = refclk_ff >> shift;
      dv_valid_in[0] = s2_valid_ff;
      dv_div_in[0]   = shifted_ref[plltw_pkg::DIVISOR_W-1:0];
      dv_rem_in[0]   = s2_dvd_ff;
      dv_quo_in[0]   = '0;
      limit          = plltw_pkg::CMP_W'({dv_div_in[0], {ND{1'b0}}});
      dv_meta_in[0]  = s2_meta_ff;
      dv_meta_in[0].ovf = (s2_meta_ff.kind == plltw_pkg::FUNC_TUNE) &&
                          (plltw_pkg::CMP_W'(s2_dvd_ff) >= limit);

      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      for (int k = 0; k < ND; k++) begin
         sub  = plltw_pkg::CMP_W'(dv_div_ff[k]) << (ND - 1 - k);
         rem  = dv_rem_ff[k];
         quo  = dv_quo_ff[k];
         meta = dv_meta_ff[k];
         if (plltw_pkg::CMP_W'(rem) >= sub) begin
            rem = plltw_pkg::DIVIDEND_W'(plltw_pkg::CMP_W'(rem) - sub);
            quo[ND-1-k] = 1'b1;
         end
         if (k == ND - 1) begin
            rsp_valid_in             = dv_valid_ff[k];
            rsp_data_in.kind         = meta.kind;
            rsp_data_in.div4_select  = meta.p;
            rsp_data_in.presc32_on   = meta.presc;
            rsp_data_in.ref_div_code = meta.rsel;
            rsp_data_in.n_overflow   = meta.ovf;
            rsp_data_in.k_code       = meta.kc;
            rsp_data_in.filter_code  = meta.fc;
            if (meta.kind == plltw_pkg::FUNC_BW) begin
               rsp_data_in.n_divider = '0;
            end else if (meta.ovf) begin
               rsp_data_in.n_divider = '1;
            end else begin
               rsp_data_in.n_divider = quo;
            end
         end else begin
            dv_valid_in[k+1] = dv_valid_ff[k];
            dv_meta_in[k+1]  = meta;
            dv_rem_in[k+1]   = rem;
            dv_div_in[k+1]   = dv_div_ff[k];
            dv_quo_in[k+1]   = quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refclk_ff    <= plltw_pkg::REF_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         refclk_ff    <= refclk_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         dv_valid_ff  <= dv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      s1_p_ff     <= s1_p_in;
      s1_presc_ff <= s1_presc_in;
      s1_base_ff  <= s1_base_in;
      s1_mhz_ff   <= s1_mhz_in;
      s1_dvd_ff   <= s1_dvd_in;
      s2_meta_ff  <= s2_meta_in;
      s2_dvd_ff   <= s2_dvd_in;
      dv_meta_ff  <= dv_meta_in;
      dv_rem_ff   <= dv_rem_in;
      dv_div_ff   <= dv_div_in;
      dv_quo_ff   <= dv_quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/plltw_checker.sv =====
`include "pll_tuning_word_calc_macros.svh"

module plltw_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input plltw_pkg::rsp_type rsp_data
);

   `PLLTW_ASSERT_DELAYED(a_latency, clock, reset, start && !busy, plltw_pkg::LATENCY, rsp_valid, "transfer in without result after fixed latency")
   `PLLTW_ASSERT_IMPLY(a_bw_clean, clock, reset, rsp_valid && rsp_data.kind == plltw_pkg::FUNC_BW, rsp_data.div4_select == 1'b0 && rsp_data.presc32_on == 1'b0 && rsp_data.ref_div_code == 2'd0 && rsp_data.n_divider == '0 && rsp_data.n_overflow == 1'b0 && rsp_data.k_code == '0, "bandwidth result has tune fields set")
   `PLLTW_ASSERT_IMPLY(a_tune_clean, clock, reset, rsp_valid && rsp_data.kind == plltw_pkg::FUNC_TUNE, rsp_data.filter_code == '0, "tune result has filter code set")
   `PLLTW_ASSERT_IMPLY(a_sat, clock, reset, rsp_valid && rsp_data.n_overflow, rsp_data.n_divider == '1 && rsp_data.kind == plltw_pkg::FUNC_TUNE, "overflow without saturated divider")

endmodule

bind pll_tuning_word_calc plltw_checker u_plltw_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
